FILE: src/plm_pkg.sv
`timescale 1ns / 1ps

package plm_pkg;

    // Field widths fixed by the item and register formats
    localparam int ADDR_W     = 32;
    localparam int SEQ_W      = 16;
    localparam int IDENT_W    = 16;
    localparam int OUT_SEQ_W  = 4;
    localparam int COUNT_W    = 5;
    localparam int DELAY_W    = 22;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PINGS_PER_RUN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLIES_NEEDED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS    = 2'd3;

    // Item kinds
    localparam logic MODE_TIMER = 1'b0;
    localparam logic MODE_ECHO  = 1'b1;

    // Register reset values
    localparam logic [ADDR_W-1:0]  TARGET_ADDRESS_RESET = 32'd0;
    localparam logic [COUNT_W-1:0] PINGS_PER_RUN_RESET  = 5'd4;
    localparam logic [COUNT_W-1:0] REPLIES_NEEDED_RESET = 5'd1;
    localparam logic [DELAY_W-1:0] INTERVAL_MS_RESET    = 22'd10000;

    // Delay between pings of one run
    localparam logic [DELAY_W-1:0] SHORT_DELAY_MS = 22'd1000;

    typedef struct packed {
        logic [ADDR_W-1:0]  target_address;
        logic [COUNT_W-1:0] pings_per_run;
        logic [COUNT_W-1:0] replies_needed;
        logic [DELAY_W-1:0] interval_ms;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [ADDR_W-1:0]  echo_addr;
        logic [SEQ_W-1:0]   echo_seq;
        logic [IDENT_W-1:0] echo_ident;
        logic [IDENT_W-1:0] fresh_ident;
    } item_t;

    typedef struct packed {
        logic                 send_ping;
        logic [OUT_SEQ_W-1:0] ping_seq;
        logic [IDENT_W-1:0]   ping_ident;
        logic                 arm_timer;
        logic [DELAY_W-1:0]   delay_ms;
        logic                 state_changed;
        logic                 host_up;
    } result_t;

endpackage

FILE: src/plm_if.sv
`timescale 1ns / 1ps

// Event channel: timer expiries and echo replies
interface plm_event_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [plm_pkg::ADDR_W-1:0]    echo_addr;
    logic [plm_pkg::SEQ_W-1:0]     echo_seq;
    logic [plm_pkg::IDENT_W-1:0]   echo_ident;
    logic [plm_pkg::IDENT_W-1:0]   fresh_ident;

    modport source (output valid, mode, echo_addr, echo_seq, echo_ident, fresh_ident,
                    input ready);
    modport sink   (input valid, mode, echo_addr, echo_seq, echo_ident, fresh_ident,
                    output ready);
endinterface

// Action channel: ping requests, timer arming and status
interface plm_action_if;
    logic                            valid;
    logic                            ready;
    logic                            send_ping;
    logic [plm_pkg::OUT_SEQ_W-1:0]   ping_seq;
    logic [plm_pkg::IDENT_W-1:0]     ping_ident;
    logic                            arm_timer;
    logic [plm_pkg::DELAY_W-1:0]     delay_ms;
    logic                            state_changed;
    logic                            host_up;

    modport source (output valid, send_ping, ping_seq, ping_ident, arm_timer, delay_ms,
                    state_changed, host_up,
                    input ready);
    modport sink   (input valid, send_ping, ping_seq, ping_ident, arm_timer, delay_ms,
                    state_changed, host_up,
                    output ready);
endinterface

FILE: src/plm_cfg.sv
`timescale 1ns / 1ps

module plm_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output plm_pkg::cfg_t                      cfg
);

    plm_pkg::cfg_t cfg_reg;
    plm_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                plm_pkg::REG_TARGET_ADDRESS:
                    cfg_next.target_address = cfg_data[plm_pkg::ADDR_W-1:0];
                plm_pkg::REG_PINGS_PER_RUN:
                    cfg_next.pings_per_run = cfg_data[plm_pkg::COUNT_W-1:0];
                plm_pkg::REG_REPLIES_NEEDED:
                    cfg_next.replies_needed = cfg_data[plm_pkg::COUNT_W-1:0];
                plm_pkg::REG_INTERVAL_MS:
                    cfg_next.interval_ms = cfg_data[plm_pkg::DELAY_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_address <= plm_pkg::TARGET_ADDRESS_RESET;
            cfg_reg.pings_per_run  <= plm_pkg::PINGS_PER_RUN_RESET;
            cfg_reg.replies_needed <= plm_pkg::REPLIES_NEEDED_RESET;
            cfg_reg.interval_ms    <= plm_pkg::INTERVAL_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/plm_core.sv
`timescale 1ns / 1ps

module plm_core
#(
    parameter int MAX_PINGS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  plm_pkg::cfg_t     cfg,
    input  plm_pkg::item_t    item,
    output plm_pkg::result_t  result
);

    // Phase runs 1..p+1 with p at most min(MAX_PINGS, 31)
    localparam int PW  = $clog2(MAX_PINGS + 2);
    localparam int CW  = (PW > plm_pkg::COUNT_W) ? PW : plm_pkg::COUNT_W;
    localparam int NW  = $clog2(MAX_PINGS + 1);
    localparam int TW  = (NW > plm_pkg::COUNT_W) ? NW : plm_pkg::COUNT_W;
    localparam int PINGS_RST_INT = int'(plm_pkg::PINGS_PER_RUN_RESET);
    localparam int PHASE_RST_INT = (PINGS_RST_INT < 1) ? 1 :
                                   ((PINGS_RST_INT > MAX_PINGS) ? MAX_PINGS : PINGS_RST_INT);
    localparam logic [PW-1:0] PHASE_RESET = PW'(PHASE_RST_INT);

    logic [MAX_PINGS-1:0]         marks_reg, marks_next;
    logic [PW-1:0]                phase_reg, phase_next;
    logic [plm_pkg::IDENT_W-1:0]  ident_reg, ident_next;
    logic                         up_reg, up_next;

    logic [CW-1:0]                ppr_ext;
    logic [CW-1:0]                p_eff;
    logic [CW-1:0]                phase_ext;
    logic [NW-1:0]                reply_count;
    logic                         addr_hit;
    logic                         seq_in_range;
    plm_pkg::result_t             res;

    // Clamp the ping count to 1..MAX_PINGS
    always_comb
    begin
        ppr_ext = CW'(cfg.pings_per_run);
        if (ppr_ext == '0)
            p_eff = CW'(1);
        else if (ppr_ext > CW'(MAX_PINGS))
            p_eff = CW'(MAX_PINGS);
        else
            p_eff = ppr_ext;
    end

    assign phase_ext = CW'(phase_reg);

    // Count the marked replies inside the current run
    always_comb
    begin
        reply_count = '0;
        for (int i = 0; i < MAX_PINGS; i++)
        begin
            if (marks_reg[i] && (CW'(i) < p_eff))
                reply_count = reply_count + NW'(1);
        end
    end

    assign addr_hit     = (item.echo_addr == cfg.target_address) &&
                          (item.echo_ident == ident_reg);
    assign seq_in_range = (item.echo_seq < plm_pkg::SEQ_W'(p_eff));

    // Work out the next state and the result of the item
    always_comb
    begin
        marks_next = marks_reg;
        phase_next = phase_reg;
        ident_next = ident_reg;
        up_next    = up_reg;
        res        = '0;

        if (item.mode == plm_pkg::MODE_TIMER)
        begin
            res.arm_timer = 1'b1;
            if (phase_ext == p_eff)
            begin
                // End of run: evaluate replies against the threshold
                up_next           = (TW'(reply_count) >= TW'(cfg.replies_needed));
                res.state_changed = (up_next != up_reg);
                phase_next        = PW'(p_eff + CW'(1));
                res.delay_ms      = cfg.interval_ms;
            end
            else if (phase_ext > p_eff)
            begin
                // Start a fresh run with sequence 0
                marks_next    = '0;
                ident_next    = item.fresh_ident;
                phase_next    = PW'(1);
                res.send_ping = 1'b1;
                res.ping_seq  = '0;
                res.delay_ms  = plm_pkg::SHORT_DELAY_MS;
            end
            else
            begin
                res.send_ping = 1'b1;
                res.ping_seq  = phase_reg[plm_pkg::OUT_SEQ_W-1:0];
                phase_next    = phase_reg + PW'(1);
                res.delay_ms  = plm_pkg::SHORT_DELAY_MS;
            end
        end
        else
        begin
            // Mark the reply slot of a matching echo
            if (addr_hit && seq_in_range)
            begin
                for (int i = 0; i < MAX_PINGS; i++)
                begin
                    if (item.echo_seq == plm_pkg::SEQ_W'(i))
                        marks_next[i] = 1'b1;
                end
            end
        end

        res.ping_ident = ident_next;
        res.host_up    = up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '1;
            phase_reg <= PHASE_RESET;
            ident_reg <= '0;
            up_reg    <= 1'b1;
        end
        else if (fire)
        begin
            marks_reg <= marks_next;
            phase_reg <= phase_next;
            ident_reg <= ident_next;
            up_reg    <= up_next;
        end
    end

    assign result = res;

endmodule

FILE: src/ping_liveness_monitor.sv
`timescale 1ns / 1ps
// An accepted event is held in the input register, then its result in the result register.
// Throughput: one event per cycle while actions.ready is high; input refills as output drains.
// The event and result registers each hold one item; the monitor state updates in one pass.
// Reset: bitmap all ones, phase equal to the clamped ping count, run ident zero, host up,
// registers at their defaults, both channels empty.

module ping_liveness_monitor
#(
    parameter int MAX_PINGS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    plm_event_if.sink                          events,
    plm_action_if.source                       actions,
    input  logic                               cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    plm_pkg::cfg_t     cfg;
    plm_pkg::item_t    item_reg;
    plm_pkg::result_t  result_reg;
    plm_pkg::result_t  core_result;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              take_in;

    plm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plm_core #(.MAX_PINGS(MAX_PINGS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .cfg    (cfg),
        .item   (item_reg),
        .result (core_result)
    );

    // Move the held item on when the result register is free or draining
    assign advance        = in_valid_reg && (!out_valid_reg || actions.ready);
    assign events.ready   = !in_valid_reg || advance;
    assign take_in        = events.valid && events.ready;
    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !actions.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.mode        <= events.mode;
            item_reg.echo_addr   <= events.echo_addr;
            item_reg.echo_seq    <= events.echo_seq;
            item_reg.echo_ident  <= events.echo_ident;
            item_reg.fresh_ident <= events.fresh_ident;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= core_result;
    end

    assign actions.valid         = out_valid_reg;
    assign actions.send_ping     = result_reg.send_ping;
    assign actions.ping_seq      = result_reg.ping_seq;
    assign actions.ping_ident    = result_reg.ping_ident;
    assign actions.arm_timer     = result_reg.arm_timer;
    assign actions.delay_ms      = result_reg.delay_ms;
    assign actions.state_changed = result_reg.state_changed;
    assign actions.host_up       = result_reg.host_up;

endmodule

FILE: tb/plm_action_checker.sv
`timescale 1ns / 1ps

module plm_action_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    plm_event_if                           ev,
    plm_action_if                          act,
    input  logic                           cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             error_count,
    output int                             outstanding
);

    localparam int MAX_PINGS = 16;

    // Shadow copy of the registers and the monitor state
    plm_pkg::cfg_t                   settings;
    logic [MAX_PINGS-1:0]            reply_marks;
    logic [plm_pkg::COUNT_W-1:0]     phase;
    logic [plm_pkg::IDENT_W-1:0]     run_ident;
    logic                            host_up;

    plm_pkg::result_t                expected_actions[$];
    int                              mismatches = 0;

    assign error_count = mismatches;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Ping count as the monitor uses it: held to 1..MAX_PINGS
    function automatic logic [plm_pkg::COUNT_W-1:0] clamp_pings(
        input logic [plm_pkg::COUNT_W-1:0] n);
        if (n == '0)
            return plm_pkg::COUNT_W'(1);
        if (n > plm_pkg::COUNT_W'(MAX_PINGS))
            return plm_pkg::COUNT_W'(MAX_PINGS);
        return n;
    endfunction

    // Advance the shadow monitor by one item and queue the action it causes
    task automatic predict_action(input logic                        mode,
                                  input logic [plm_pkg::ADDR_W-1:0]  addr,
                                  input logic [plm_pkg::SEQ_W-1:0]   seq,
                                  input logic [plm_pkg::IDENT_W-1:0] ident,
                                  input logic [plm_pkg::IDENT_W-1:0] fresh);
        plm_pkg::result_t             r;
        logic [plm_pkg::COUNT_W-1:0]  p;
        logic [MAX_PINGS-1:0]         window;
        logic                         verdict;
        r = '0;
        p = clamp_pings(settings.pings_per_run);
        if (mode == plm_pkg::MODE_TIMER)
        begin
            r.arm_timer = 1'b1;
            if (phase == p)
            begin
                // Last ping done: count replies and settle the flag
                window  = reply_marks & ((MAX_PINGS'(1) << p) - MAX_PINGS'(1));
                verdict = ($countones(window) >= int'(settings.replies_needed));
                if (verdict != host_up)
                begin
                    host_up         = verdict;
                    r.state_changed = 1'b1;
                end
                phase      = p + plm_pkg::COUNT_W'(1);
                r.delay_ms = settings.interval_ms;
            end
            else
            begin
                // Send the next ping; past the run, first open a new one with the fresh identifier
                if (phase > p)
                begin
                    reply_marks = '0;
                    run_ident   = fresh;
                    phase       = '0;
                end
                r.send_ping = 1'b1;
                r.ping_seq  = phase[plm_pkg::OUT_SEQ_W-1:0];
                phase       = phase + plm_pkg::COUNT_W'(1);
                r.delay_ms  = plm_pkg::SHORT_DELAY_MS;
            end
        end
        else if (addr == settings.target_address && ident == run_ident &&
                 seq < plm_pkg::SEQ_W'(p))
        begin
            reply_marks[seq[3:0]] = 1'b1;
        end
        r.ping_ident = run_ident;
        r.host_up    = host_up;
        expected_actions = {expected_actions, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        plm_pkg::result_t want;
        if (!rst_n)
        begin
            settings    = '{plm_pkg::TARGET_ADDRESS_RESET, plm_pkg::PINGS_PER_RUN_RESET,
                            plm_pkg::REPLIES_NEEDED_RESET, plm_pkg::INTERVAL_MS_RESET};
            reply_marks = '1;
            phase       = clamp_pings(plm_pkg::PINGS_PER_RUN_RESET);
            run_ident   = '0;
            host_up     = 1'b1;
            expected_actions.delete();
            outstanding <= 0;
        end
        else
        begin
            // Check the departing action before queueing a new one
            if (act.valid && act.ready)
            begin
                if (expected_actions.size() == 0)
                    report("action item with nothing expected");
                else
                begin
                    want = expected_actions.pop_front();
                    compare_field("send_ping", longint'(act.send_ping),
                                  longint'(want.send_ping));
                    compare_field("ping_seq", longint'(act.ping_seq),
                                  longint'(want.ping_seq));
                    compare_field("ping_ident", longint'(act.ping_ident),
                                  longint'(want.ping_ident));
                    compare_field("arm_timer", longint'(act.arm_timer),
                                  longint'(want.arm_timer));
                    compare_field("delay_ms", longint'(act.delay_ms),
                                  longint'(want.delay_ms));
                    compare_field("state_changed", longint'(act.state_changed),
                                  longint'(want.state_changed));
                    compare_field("host_up", longint'(act.host_up),
                                  longint'(want.host_up));
                end
            end

            if (ev.valid && ev.ready)
                predict_action(ev.mode, ev.echo_addr, ev.echo_seq, ev.echo_ident,
                               ev.fresh_ident);

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    plm_pkg::REG_TARGET_ADDRESS:
                        settings.target_address = cfg_data[plm_pkg::ADDR_W-1:0];
                    plm_pkg::REG_PINGS_PER_RUN:
                        settings.pings_per_run  = cfg_data[plm_pkg::COUNT_W-1:0];
                    plm_pkg::REG_REPLIES_NEEDED:
                        settings.replies_needed = cfg_data[plm_pkg::COUNT_W-1:0];
                    plm_pkg::REG_INTERVAL_MS:
                        settings.interval_ms    = cfg_data[plm_pkg::DELAY_W-1:0];
                    default: ;
                endcase
            end

            outstanding <= expected_actions.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [plm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [plm_pkg::CFG_DATA_W-1:0] cfg_data;

    int                             error_count;
    int                             outstanding;
    int                             cycle_count;

    int                             sender_idle_pct = 0;
    int                             recv_stall_pct  = 0;

    // Stimulus view of the run in progress
    int                             run_pos = 4;
    logic [plm_pkg::IDENT_W-1:0]    cur_ident = '0;
    logic [plm_pkg::ADDR_W-1:0]     target = '0;

    plm_event_if  ev_ch();
    plm_action_if act_ch();

    ping_liveness_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev_ch),
        .actions   (act_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plm_action_checker action_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev_ch),
        .act         (act_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Stall the action channel at random
    always @(posedge clk)
        act_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Offer one item, with random gaps ahead, and hold it until taken
    task automatic offer_event(input logic                        mode,
                               input logic [plm_pkg::ADDR_W-1:0]  addr,
                               input logic [plm_pkg::SEQ_W-1:0]   seq,
                               input logic [plm_pkg::IDENT_W-1:0] ident,
                               input logic [plm_pkg::IDENT_W-1:0] fresh);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            ev_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ev_ch.valid       <= 1'b1;
        ev_ch.mode        <= mode;
        ev_ch.echo_addr   <= addr;
        ev_ch.echo_seq    <= seq;
        ev_ch.echo_ident  <= ident;
        ev_ch.fresh_ident <= fresh;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every action has come back
    task automatic wait_drained();
        ev_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Reconfigure while idle, then drive runs of pings mixed with echoes and noise
    task automatic run_phase(input logic [plm_pkg::ADDR_W-1:0]  tgt,
                             input logic [plm_pkg::COUNT_W-1:0] pings,
                             input logic [plm_pkg::COUNT_W-1:0] needed,
                             input logic [plm_pkg::DELAY_W-1:0] interval,
                             input int                          s_idle,
                             input int                          r_stall,
                             input int                          n_items);
        logic [plm_pkg::CFG_DATA_W-1:0] values [4];
        logic [plm_pkg::IDENT_W-1:0]    fresh;
        int                             p;
        int                             roll;
        wait_drained();
        sender_idle_pct = s_idle;
        recv_stall_pct  = r_stall;
        values[plm_pkg::REG_TARGET_ADDRESS] = tgt;
        values[plm_pkg::REG_PINGS_PER_RUN]  = plm_pkg::CFG_DATA_W'(pings);
        values[plm_pkg::REG_REPLIES_NEEDED] = plm_pkg::CFG_DATA_W'(needed);
        values[plm_pkg::REG_INTERVAL_MS]    = plm_pkg::CFG_DATA_W'(interval);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= plm_pkg::CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        target = tgt;
        p = (pings == '0) ? 1 : ((int'(pings) > 16) ? 16 : int'(pings));

        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                offer_event(plm_pkg::MODE_ECHO, $urandom, plm_pkg::SEQ_W'($urandom),
                            plm_pkg::IDENT_W'($urandom), plm_pkg::IDENT_W'($urandom));
            else if (roll < 45 && run_pos >= 1 && run_pos <= p)
                offer_event(plm_pkg::MODE_ECHO, target,
                            plm_pkg::SEQ_W'($urandom_range(0, run_pos - 1)), cur_ident,
                            plm_pkg::IDENT_W'($urandom));
            else if (roll < 58)
            begin
                // Echo that is right in all but one field
                case ($urandom_range(0, 2))
                    0: offer_event(plm_pkg::MODE_ECHO,
                                   target ^ (32'd1 << $urandom_range(0, 31)),
                                   plm_pkg::SEQ_W'($urandom_range(0, p - 1)), cur_ident,
                                   plm_pkg::IDENT_W'($urandom));
                    1: offer_event(plm_pkg::MODE_ECHO, target,
                                   plm_pkg::SEQ_W'($urandom_range(0, p - 1)),
                                   cur_ident ^ (16'd1 << $urandom_range(0, 15)),
                                   plm_pkg::IDENT_W'($urandom));
                    default: offer_event(plm_pkg::MODE_ECHO, target,
                                         plm_pkg::SEQ_W'($urandom_range(p, 65535)),
                                         cur_ident, plm_pkg::IDENT_W'($urandom));
                endcase
            end
            else
            begin
                fresh = plm_pkg::IDENT_W'($urandom);
                offer_event(plm_pkg::MODE_TIMER, $urandom, plm_pkg::SEQ_W'($urandom),
                            plm_pkg::IDENT_W'($urandom), fresh);
                if (run_pos > p)
                begin
                    run_pos   = 1;
                    cur_ident = fresh;
                end
                else
                    run_pos++;
            end
        end
    endtask

    // Give up after a generous number of cycles
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        ev_ch.valid       = 1'b0;
        ev_ch.mode        = plm_pkg::MODE_TIMER;
        ev_ch.echo_addr   = '0;
        ev_ch.echo_seq    = '0;
        ev_ch.echo_ident  = '0;
        ev_ch.fresh_ident = '0;
        act_ch.ready      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset leaves the phase at the count, so the first expiry evaluates
        offer_event(plm_pkg::MODE_TIMER, '1, '1, '1, 16'h1234);
        offer_event(plm_pkg::MODE_TIMER, '0, '0, '0, 16'hFFFF);
        offer_event(plm_pkg::MODE_ECHO, '0, 16'd0, 16'hFFFF, '0);
        // Ignored echoes: sequence past the run, wrong address, wrong identifier
        offer_event(plm_pkg::MODE_ECHO, '0, 16'hFFFF, 16'hFFFF, '0);
        offer_event(plm_pkg::MODE_ECHO, '1, 16'd1, 16'hFFFF, '0);
        offer_event(plm_pkg::MODE_ECHO, '0, 16'd1, 16'h0000, '0);
        repeat (3) offer_event(plm_pkg::MODE_TIMER, '0, '0, '0, '1);
        offer_event(plm_pkg::MODE_ECHO, '0, 16'd3, 16'hFFFF, '0);
        offer_event(plm_pkg::MODE_ECHO, '0, 16'd4, 16'hFFFF, '0);
        offer_event(plm_pkg::MODE_TIMER, '0, '0, '0, '0);
        // Silent run: the host goes down
        offer_event(plm_pkg::MODE_TIMER, '0, '0, '0, 16'h0000);
        repeat (3) offer_event(plm_pkg::MODE_TIMER, '1, '1, '1, '1);
        offer_event(plm_pkg::MODE_TIMER, '0, '0, '0, '0);
        run_pos   = 5;
        cur_ident = '0;

        // Extremes first, then out-of-range counts, zero interval and mid-run changes
        run_phase('1, 5'd16, 5'd16, 22'd3600000, 0, 0, 90);
        run_phase($urandom, 5'd1, 5'd0, 22'd1, 58, 0, 80);
        run_phase($urandom, 5'd0, 5'd1, 22'd0, 0, 58, 80);
        run_phase($urandom, 5'd31, 5'd17, 22'h3FFFFF, 17, 17, 90);
        run_phase($urandom, 5'd7, 5'd3, plm_pkg::DELAY_W'($urandom_range(0, 4194303)),
                  0, 0, 60);
        run_phase($urandom, 5'd3, 5'd2, 22'd1000, 58, 0, 60);
        run_phase($urandom, 5'd12, 5'd31, plm_pkg::DELAY_W'($urandom_range(0, 4194303)),
                  17, 17, 80);

        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
